[hdl/sha256_message_digest_macros.svh]
// Assertion macros shared by the digest RTL.
// Depends on a clock named clk and a reset named rst in the using module.
`ifndef SHA256_MESSAGE_DIGEST_MACROS_SVH
`define SHA256_MESSAGE_DIGEST_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define SHAMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SHAMD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/shamd_pkg.sv]
// Types, constants and round functions of the SHA-256 digest block.
// Used by shamd_window, shamd_core and sha256_message_digest.
package shamd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       is_last;
  } msg_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } dig_t;

  typedef struct packed {
    logic shift_byte;
    logic shift_word;
  } win_ctl_t;

  typedef struct packed {
    logic init_vars;
    logic round_en;
    logic update;
    logic reload;
  } core_ctl_t;

  localparam int unsigned CountW = 61;
  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LenOffset = 6'd56;
  localparam logic [5:0] LastSlot = 6'd63;
  localparam logic [5:0] LastRound = 6'd63;
  localparam logic [2:0] LastWord = 3'd7;

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] h;
    case (i)
      3'd0: h = 32'h6a09e667;
      3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372;
      3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f;
      3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;
      default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

[hdl/shamd_window.sv]
// Block buffer and message schedule window as one 512-bit shift line.
// Bytes shift in during loading, words shift during rounds. Uses shamd_pkg.
module shamd_window (
  input  logic                clk,
  input  shamd_pkg::win_ctl_t ctl,
  input  logic [7:0]          byte_in,
  output logic [31:0]         w_cur
);

  logic [511:0] win;
  logic [31:0]  w_new;

  assign w_cur = win[511:480];
  assign w_new = shamd_pkg::small_sigma1(win[63:32]) + win[223:192]
               + shamd_pkg::small_sigma0(win[479:448]) + win[511:480];

  always_ff @(posedge clk) begin
    if (ctl.shift_byte) begin
      win <= {win[503:0], byte_in};
    end else if (ctl.shift_word) begin
      win <= {win[479:0], w_new};
    end
  end

endmodule

[hdl/shamd_core.sv]
// Compression round unit: chaining value, working variables, one round a cycle.
// Takes its control from the sequencer in sha256_message_digest. Uses shamd_pkg.
module shamd_core (
  input  logic                 clk,
  input  logic                 rst,
  input  shamd_pkg::core_ctl_t ctl,
  input  logic [5:0]           round_idx,
  input  logic [31:0]          w_in,
  input  logic [2:0]           rd_idx,
  output logic [31:0]          rd_word
);

  logic [31:0] chain [8];
  logic [31:0] v [8];
  logic [31:0] t1;
  logic [31:0] t2;

  assign rd_word = chain[rd_idx];

  assign t1 = v[7] + shamd_pkg::big_sigma1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
            + shamd_pkg::round_k(round_idx) + w_in;
  assign t2 = shamd_pkg::big_sigma0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) begin
      if (rst || ctl.reload) begin
        chain[i] <= shamd_pkg::init_hash(3'(i));
      end else if (ctl.update) begin
        chain[i] <= chain[i] + v[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.init_vars) begin
      for (int i = 0; i < 8; i++) begin
        v[i] <= chain[i];
      end
    end else if (ctl.round_en) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

endmodule

[hdl/sha256_message_digest.sv]
// SHA-256 digest of a byte stream: sequencer, padding and digest output.
// Instantiates shamd_window and shamd_core; uses shamd_pkg and the macro header.
//
//   channel | wires                        | beat
//   msg     | msg_valid, msg_stall, msg    | one message byte and flags
//   dig     | dig_valid, dig_stall, dig    | one digest word, index 0 to 7
//
// A byte that does not fill a block is only shifted in; a byte that fills one
// also starts the load, 64 rounds of the shared round unit and chain update.
// A last beat adds the padding bytes and a round set per padding block, then
// eight output beats. msg_stall is high whenever the sequencer is not idle.
// Synchronous reset loads the initial hash and clears the byte count.
// dig holds steady while dig_stall is high.
`include "sha256_message_digest_macros.svh"

module sha256_message_digest (
  input  logic              clk,
  input  logic              rst,
  input  logic              msg_valid,
  output logic              msg_stall,
  input  shamd_pkg::msg_t   msg,
  output logic              dig_valid,
  input  logic              dig_stall,
  output shamd_pkg::dig_t   dig
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_UPDATE,
    S_PAD,
    S_OUT
  } state_t;

  state_t                    state;
  logic [shamd_pkg::CountW-1:0] byte_count;
  logic [5:0]                fill;
  logic [5:0]                rnd;
  logic [2:0]                out_idx;
  logic                      last_pend;
  logic                      mark_sent;
  logic                      len_block;

  logic                      msg_take;
  logic                      dig_take;
  logic [63:0]               bit_len;
  logic [2:0]                len_sel;
  logic [7:0]                pad_byte;
  logic [7:0]                byte_in;
  logic [31:0]               w_cur;
  logic [31:0]               rd_word;
  logic                      go_round;
  shamd_pkg::win_ctl_t       win_ctl;
  shamd_pkg::core_ctl_t      core_ctl;

  assign msg_stall = (state != S_IDLE);
  assign msg_take  = msg_valid && !msg_stall;
  assign dig_take  = dig_valid && !dig_stall;

  assign bit_len = {byte_count, 3'b000};
  assign len_sel = 3'd7 - fill[2:0];

  always_comb begin
    if (!mark_sent) begin
      pad_byte = shamd_pkg::PadMark;
    end else if (len_block && (fill >= shamd_pkg::LenOffset)) begin
      pad_byte = bit_len[{len_sel, 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign byte_in  = (state == S_PAD) ? pad_byte : msg.data_byte;
  assign go_round = (fill == shamd_pkg::LastSlot)
                 && ((msg_take && msg.byte_valid) || (state == S_PAD));

  assign win_ctl.shift_byte = (msg_take && msg.byte_valid) || (state == S_PAD);
  assign win_ctl.shift_word = (state == S_ROUND);

  assign core_ctl.init_vars = go_round;
  assign core_ctl.round_en  = (state == S_ROUND);
  assign core_ctl.update    = (state == S_UPDATE);
  assign core_ctl.reload    = dig_take && (out_idx == shamd_pkg::LastWord);

  assign dig.digest_word = rd_word;
  assign dig.word_index  = out_idx;
  assign dig.last_word   = (out_idx == shamd_pkg::LastWord);

  shamd_window u_window (
    .clk     (clk),
    .ctl     (win_ctl),
    .byte_in (byte_in),
    .w_cur   (w_cur)
  );

  shamd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .ctl       (core_ctl),
    .round_idx (rnd),
    .w_in      (w_cur),
    .rd_idx    (out_idx),
    .rd_word   (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      byte_count <= '0;
      fill       <= '0;
      rnd        <= '0;
      out_idx    <= '0;
      last_pend  <= 1'b0;
      mark_sent  <= 1'b0;
      len_block  <= 1'b0;
      dig_valid  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (msg_take) begin
            last_pend <= msg.is_last;
            if (msg.byte_valid) begin
              byte_count <= byte_count + 1'b1;
              fill       <= fill + 1'b1;
            end
            if (go_round) begin
              state <= S_ROUND;
            end else if (msg.is_last) begin
              state <= S_PAD;
            end
          end
        end
        S_ROUND: begin
          rnd <= rnd + 1'b1;
          if (rnd == shamd_pkg::LastRound) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (len_block) begin
            state     <= S_OUT;
            out_idx   <= '0;
            dig_valid <= 1'b1;
          end else if (mark_sent) begin
            len_block <= 1'b1;
            state     <= S_PAD;
          end else if (last_pend) begin
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_PAD: begin
          fill <= fill + 1'b1;
          if (!mark_sent) begin
            mark_sent <= 1'b1;
            if (fill < shamd_pkg::LenOffset) begin
              len_block <= 1'b1;
            end
          end
          if (fill == shamd_pkg::LastSlot) begin
            state <= S_ROUND;
          end
        end
        S_OUT: begin
          if (!dig_stall) begin
            if (out_idx == shamd_pkg::LastWord) begin
              dig_valid  <= 1'b0;
              state      <= S_IDLE;
              byte_count <= '0;
              fill       <= '0;
              last_pend  <= 1'b0;
              mark_sent  <= 1'b0;
              len_block  <= 1'b0;
            end else begin
              out_idx <= out_idx + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SHAMD_ASSERT(a_out_blocks_in, dig_valid |-> msg_stall, "input taken during digest output")
  `SHAMD_ASSERT(a_update_after_rounds, (state == S_UPDATE) |-> (rnd == 6'd0 && $past(state) == S_ROUND), "chain update not after full round set")
  `SHAMD_ASSERT(a_len_needs_mark, len_block |-> mark_sent, "length block without pad mark")
  `SHAMD_ASSERT(a_clear_after_digest, (dig_take && dig.last_word) |=> (state == S_IDLE && byte_count == '0 && fill == 6'd0), "state not cleared after digest")
  `SHAMD_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == S_IDLE && !dig_valid), "reset did not idle the sequencer")

endmodule

[tb/sv/sha256_message_digest_tb.sv]
// Self-checking testbench for sha256_message_digest: directed and random messages
// fed a byte per beat, digest words checked against a SHA-256 predictor kept here.
// Depends on shamd_pkg for the beat types and on the sha256_message_digest RTL.
`timescale 1ns / 1ps

module sha256_message_digest_tb;

  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned RandomItems = 210;

  localparam logic [255:0] SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [64*32-1:0] SHA_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic msg_valid = 1'b0;
  logic msg_stall;
  shamd_pkg::msg_t msg = '0;
  logic dig_valid;
  logic dig_stall = 1'b0;
  shamd_pkg::dig_t dig;

  logic [31:0] chain_h [8];
  logic [7:0] blk [64];
  logic [shamd_pkg::CountW-1:0] msg_bytes;
  shamd_pkg::dig_t pending_words [$];

  int mismatches = 0;
  int burst_left = 1;
  int idle_cycles = 0;
  int stall_mode = 0;
  int stall_count = 0;

  sha256_message_digest i_dut (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg       (msg),
    .dig_valid (dig_valid),
    .dig_stall (dig_stall),
    .dig       (dig)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void reset_digest_state();
    for (int i = 0; i < 8; i++) chain_h[i] = SHA_IV[(7 - i) * 32 +: 32];
    msg_bytes = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, wt, x15, x2;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk[4 * i], blk[4 * i + 1], blk[4 * i + 2], blk[4 * i + 3]};
    end
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
    e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        wt = w[r];
      end else begin
        x15 = w[(r - 15) & 15];
        x2 = w[(r - 2) & 15];
        wt = w[r & 15] + (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3)) + w[(r - 7) & 15]
           + (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10));
        w[r & 15] = wt;
      end
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + SHA_K[(63 - r) * 32 +: 32] + wt;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
    chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
  endfunction

  // Absorb one accepted beat; on the last mark pad, finish and queue eight words.
  function automatic void absorb_beat(input shamd_pkg::msg_t beat);
    int pos;
    logic [63:0] bit_len;
    shamd_pkg::dig_t word;
    if (beat.byte_valid) begin
      blk[msg_bytes[5:0]] = beat.data_byte;
      msg_bytes = msg_bytes + 1'b1;
      if (msg_bytes[5:0] == 6'd0) compress_block();
    end
    if (!beat.is_last) return;
    pos = int'(msg_bytes[5:0]);
    blk[pos] = shamd_pkg::PadMark;
    for (int i = pos + 1; i < 64; i++) blk[i] = 8'h00;
    if (pos >= int'(shamd_pkg::LenOffset)) begin
      compress_block();
      for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    end
    bit_len = {msg_bytes, 3'b000};
    for (int i = 0; i < 8; i++) begin
      blk[shamd_pkg::LenOffset + 6'(i)] = bit_len[(7 - i) * 8 +: 8];
    end
    compress_block();
    for (int i = 0; i < 8; i++) begin
      word.digest_word = chain_h[i];
      word.word_index = i[2:0];
      word.last_word = (i == 7);
      pending_words.push_back(word);
    end
    reset_digest_state();
  endfunction

  function automatic shamd_pkg::msg_t make_beat(input logic [7:0] data, input logic valid,
                                                input logic last);
    shamd_pkg::msg_t beat;
    beat.data_byte = data;
    beat.byte_valid = valid;
    beat.is_last = last;
    return beat;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h, want %h (t=%0t)", what, got, want, $time);
    mismatches++;
  endtask

  // Hold the beat until accepted, then advance the burst or insert a gap.
  task automatic send_item(input shamd_pkg::msg_t beat);
    msg <= beat;
    msg_valid <= 1'b1;
    @(posedge clk);
    while (msg_stall) @(posedge clk);
    absorb_beat(beat);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 48);
      if ($urandom_range(0, 3) != 0) begin
        msg_valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  endtask

  always @(posedge clk) begin
    if (stall_count == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_count <= $urandom_range(16, 96);
    end else begin
      stall_count <= stall_count - 1;
    end
    case (stall_mode)
      0: dig_stall <= 1'b0;
      1: dig_stall <= ~dig_stall;
      2: dig_stall <= ($urandom_range(0, 2) == 0);
      default: dig_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    shamd_pkg::dig_t want;
    if (!rst && dig_valid && !dig_stall) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected digest word", dig.digest_word, 32'h0);
      end else begin
        want = pending_words.pop_front();
        if (dig.digest_word !== want.digest_word)
          report_mismatch("digest_word", dig.digest_word, want.digest_word);
        if (dig.word_index !== want.word_index)
          report_mismatch("word_index", dig.word_index, want.word_index);
        if (dig.last_word !== want.last_word)
          report_mismatch("last_word", dig.last_word, want.last_word);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (msg_valid && !msg_stall) || (dig_valid && !dig_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("sha256_message_digest regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_empty_message();
    send_item(make_beat(8'h00, 1'b0, 1'b1));
  endtask

  task automatic test_single_byte();
    send_item(make_beat(8'h00, 1'b1, 1'b1));
    send_item(make_beat(8'hff, 1'b1, 1'b1));
  endtask

  task automatic test_abc_message();
    send_item(make_beat(8'h61, 1'b1, 1'b0));
    send_item(make_beat(8'h62, 1'b1, 1'b0));
    send_item(make_beat(8'h63, 1'b1, 1'b1));
  endtask

  task automatic test_ignored_and_separate_last();
    send_item(make_beat(8'hff, 1'b0, 1'b0));
    send_item(make_beat(8'h80, 1'b1, 1'b0));
    send_item(make_beat(8'h7f, 1'b0, 1'b0));
    send_item(make_beat(8'h01, 1'b1, 1'b0));
    send_item(make_beat(8'hff, 1'b0, 1'b1));
  endtask

  task automatic test_random_messages();
    int sent;
    int len;
    bit tail_mark;
    sent = 0;
    while (sent < int'(RandomItems)) begin
      case ($urandom_range(0, 7))
        5: begin
          case ($urandom_range(0, 5))
            0: len = 55;
            1: len = 56;
            2: len = 63;
            3: len = 64;
            4: len = 119;
            default: len = 120;
          endcase
        end
        6: len = $urandom_range(13, 70);
        7: len = 0;
        default: len = $urandom_range(1, 12);
      endcase
      if (len > int'(RandomItems) - sent) len = int'(RandomItems) - sent;
      tail_mark = (len == 0) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 11) == 0) begin
          send_item(make_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0));
          sent++;
        end
        send_item(make_beat(8'($urandom_range(0, 255)), 1'b1, !tail_mark && (i == len - 1)));
        sent++;
      end
      if (tail_mark) begin
        send_item(make_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1));
        sent++;
      end
    end
  endtask

  initial begin
    reset_digest_state();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_empty_message();
    test_single_byte();
    test_abc_message();
    test_ignored_and_separate_last();
    test_random_messages();
    msg_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    if (mismatches == 0) begin
      $display("sha256_message_digest regression: pass");
    end else begin
      $display("sha256_message_digest regression: fail");
    end
    $finish;
  end

endmodule
